@@ rtl/core/scs_pkg.sv @@
package scs_pkg;

  // Capacity of the entry table and the widths that follow from it.
  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Widths of the word fields.
  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 16;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // One stored entry of the coordinate list.
  typedef struct packed {
    logic [INDEX_W-1:0] row;
    logic [INDEX_W-1:0] col;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

@@ rtl/core/sparse_coo_entry_store.sv @@
// Channel   Handshake           Fields
// input     start / busy        in_func, in_row_index, in_col_index, in_entry_value
// result    out_valid (strobe)  out_read_value, out_row_pointer, out_status
//
// A word is accepted at a rising edge with start high and busy low. Each accepted
// word gives exactly one result word, shown for one cycle with out_valid high.
// A load, and any read or write that fails its range check, keeps busy low and
// shows its result in the cycle right after acceptance.
// A read, a value update and a row pointer query hold busy during a linear scan
// of the entry memory at one entry per cycle.
// A write that inserts holds busy through the scan, then a shift of the tail at
// one entry per cycle through the memory's single write port, then the write of
// the new entry.
// Reset (rst_n low, synchronous) empties the table; no clearing pass is needed.
// The receiver cannot stall, so results never wait.
module sparse_coo_entry_store
  import scs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [INDEX_W-1:0]  in_row_index,
  input  logic [INDEX_W-1:0]  in_col_index,
  input  logic [VALUE_W-1:0]  in_entry_value,
  output logic                out_valid,
  output logic [VALUE_W-1:0]  out_read_value,
  output logic [CNT_W-1:0]    out_row_pointer,
  output logic [STATUS_W-1:0] out_status
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_INSERT = 2'd3;

  // The whole coordinate list lives in one memory with a registered read port.
  entry_t entry_mem [MAX_ENTRIES];
  entry_t mem_rdata_r;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= entry_mem[mem_raddr];
  end

  // Control state.
  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [INDEX_W-1:0] largest_row_r, largest_row_nxt;
  logic [INDEX_W-1:0] largest_col_r, largest_col_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Scan and shift bookkeeping. chk_* tracks which address the read data belongs to.
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [ADDR_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic               pos_found_r, pos_found_nxt;
  logic [ADDR_W-1:0]  pos_r, pos_nxt;
  logic [ADDR_W-1:0]  sh_rd_r, sh_rd_nxt;
  logic               sh_done_r, sh_done_nxt;
  logic [CNT_W-1:0]   rp_r, rp_nxt;

  // Latched operation and result words.
  logic [FUNC_W-1:0]   op_r, op_nxt;
  logic [INDEX_W-1:0]  row_r, row_nxt;
  logic [INDEX_W-1:0]  col_r, col_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [VALUE_W-1:0]  out_read_value_r, out_read_value_nxt;
  logic [CNT_W-1:0]    out_row_pointer_r, out_row_pointer_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic table_full;
  logic scan_more;
  logic hit;

  assign table_full = (count_r == CNT_W'(MAX_ENTRIES));
  assign scan_more  = (scan_idx_r < count_r);
  assign hit        = chk_vld_r && (mem_rdata_r.row == row_r) && (mem_rdata_r.col == col_r);

  always_comb begin
    state_nxt           = state_r;
    count_nxt           = count_r;
    largest_row_nxt     = largest_row_r;
    largest_col_nxt     = largest_col_r;
    out_valid_nxt       = 1'b0;
    scan_idx_nxt        = scan_idx_r;
    chk_vld_nxt         = 1'b0;
    chk_idx_nxt         = chk_idx_r;
    pos_found_nxt       = pos_found_r;
    pos_nxt             = pos_r;
    sh_rd_nxt           = sh_rd_r;
    sh_done_nxt         = sh_done_r;
    rp_nxt              = rp_r;
    op_nxt              = op_r;
    row_nxt             = row_r;
    col_nxt             = col_r;
    val_nxt             = val_r;
    out_read_value_nxt  = out_read_value_r;
    out_row_pointer_nxt = out_row_pointer_r;
    out_status_nxt      = out_status_r;
    mem_raddr           = '0;
    mem_we              = 1'b0;
    mem_waddr           = '0;
    mem_wdata           = mem_rdata_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt              = in_func;
          row_nxt             = in_row_index;
          col_nxt             = in_col_index;
          val_nxt             = in_entry_value;
          scan_idx_nxt        = '0;
          pos_found_nxt       = 1'b0;
          pos_nxt             = '0;
          rp_nxt              = '0;
          out_read_value_nxt  = '0;
          out_row_pointer_nxt = '0;
          out_status_nxt      = ST_OK;
          unique case (in_func)
            FUNC_LOAD: begin
              out_valid_nxt = 1'b1;
              if (table_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                // Append as given; the first entry sets both largest indexes.
                if (count_r == '0 || in_row_index > largest_row_r) begin
                  largest_row_nxt = in_row_index;
                end
                if (count_r == '0 || in_col_index > largest_col_r) begin
                  largest_col_nxt = in_col_index;
                end
                mem_we          = 1'b1;
                mem_waddr       = count_r[ADDR_W-1:0];
                mem_wdata.row   = in_row_index;
                mem_wdata.col   = in_col_index;
                mem_wdata.value = in_entry_value;
                count_nxt       = count_r + CNT_W'(1);
              end
            end
            FUNC_READ, FUNC_WRITE: begin
              if (count_r == '0 || in_row_index > largest_row_r ||
                  in_col_index > largest_col_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_RANGE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            FUNC_QUERY: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; the read port is registered, so each word is checked in the cycle after its read.
        mem_raddr   = scan_idx_r[ADDR_W-1:0];
        chk_idx_nxt = scan_idx_r[ADDR_W-1:0];
        if (scan_more) begin
          chk_vld_nxt  = 1'b1;
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end
        if (chk_vld_r) begin
          unique case (op_r)
            FUNC_READ: begin
              if (hit) begin
                out_valid_nxt      = 1'b1;
                out_read_value_nxt = mem_rdata_r.value;
                state_nxt          = S_IDLE;
              end
            end
            FUNC_WRITE: begin
              if (hit) begin
                mem_we          = 1'b1;
                mem_waddr       = chk_idx_r;
                mem_wdata.value = val_r;
                out_valid_nxt   = 1'b1;
                state_nxt       = S_IDLE;
              end else if (!pos_found_r && mem_rdata_r.row >= row_r) begin
                pos_found_nxt = 1'b1;
                pos_nxt       = chk_idx_r;
              end
            end
            FUNC_QUERY: begin
              if (mem_rdata_r.row < row_r) begin
                rp_nxt = rp_r + CNT_W'(1);
              end
            end
            default: begin
              state_nxt = S_SCAN;
            end
          endcase
        end else if (!scan_more) begin
          // Scan finished without a hit.
          if (op_r == FUNC_WRITE) begin
            if (table_full) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_FULL;
              state_nxt      = S_IDLE;
            end else begin
              // With no row at or above the new one, the entry goes to the front.
              sh_rd_nxt   = ADDR_W'(count_r - CNT_W'(1));
              sh_done_nxt = 1'b0;
              state_nxt   = S_SHIFT;
            end
          end else begin
            out_valid_nxt       = 1'b1;
            out_row_pointer_nxt = (op_r == FUNC_QUERY) ? rp_r : '0;
            state_nxt           = S_IDLE;
          end
        end
      end

      S_SHIFT: begin
        // Move entries pos..count-1 up by one, highest first.
        mem_raddr = sh_rd_r;
        if (!sh_done_r) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = sh_rd_r;
          if (sh_rd_r == pos_r) begin
            sh_done_nxt = 1'b1;
          end else begin
            sh_rd_nxt = sh_rd_r - ADDR_W'(1);
          end
        end
        if (chk_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = chk_idx_r + ADDR_W'(1);
          mem_wdata = mem_rdata_r;
        end
        if (sh_done_r && !chk_vld_r) begin
          state_nxt = S_INSERT;
        end
      end

      S_INSERT: begin
        mem_we          = 1'b1;
        mem_waddr       = pos_r;
        mem_wdata.row   = row_r;
        mem_wdata.col   = col_r;
        mem_wdata.value = val_r;
        count_nxt       = count_r + CNT_W'(1);
        out_valid_nxt   = 1'b1;
        state_nxt       = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      largest_row_r <= '0;
      largest_col_r <= '0;
      out_valid_r   <= 1'b0;
      chk_vld_r     <= 1'b0;
      sh_done_r     <= 1'b0;
      pos_found_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      largest_row_r <= largest_row_nxt;
      largest_col_r <= largest_col_nxt;
      out_valid_r   <= out_valid_nxt;
      chk_vld_r     <= chk_vld_nxt;
      sh_done_r     <= sh_done_nxt;
      pos_found_r   <= pos_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r        <= scan_idx_nxt;
    chk_idx_r         <= chk_idx_nxt;
    pos_r             <= pos_nxt;
    sh_rd_r           <= sh_rd_nxt;
    rp_r              <= rp_nxt;
    op_r              <= op_nxt;
    row_r             <= row_nxt;
    col_r             <= col_nxt;
    val_r             <= val_nxt;
    out_read_value_r  <= out_read_value_nxt;
    out_row_pointer_r <= out_row_pointer_nxt;
    out_status_r      <= out_status_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_row_pointer = out_row_pointer_r;
  assign out_status      = out_status_r;

  // The table never holds more entries than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  // A failed word never carries a read value or a row pointer.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_value == '0 && out_row_pointer == '0))
    else $error("failed result carries data");

  // Only a write reaches the shift and insert phases.
  a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT || state_r == S_INSERT) |-> (op_r == FUNC_WRITE))
    else $error("shift entered by a non-write operation");

  // An insert always adds exactly one entry to a table that had room.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INSERT) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the table by one");

  // Status code three is never produced.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_RANGE || out_status == ST_FULL))
    else $error("undefined status code");

endmodule
